/* src/lakg_pkg.sv */
// ----------------------------------------------------------------------------
// lakg_pkg: shared types and constants
// Field widths, operation codes and the input item record of the lagged
// add-xor keystream generator.
// ----------------------------------------------------------------------------
package lakg_pkg;

   localparam int WORD_BITS_DEF = 64;   // default lag word width
   localparam int SEED_BITS     = 64;   // seed_value field
   localparam int KEY_BITS      = 64;   // keystream_word field
   localparam int INDEX_BITS    = 3;    // seed_index field
   localparam int SHIFT_BITS    = 5;    // shift_amount register
   localparam int X_DEPTH       = 5;
   localparam int Y_DEPTH       = 3;
   localparam int Y_IDX_BITS    = 2;

   localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = SHIFT_BITS'(2);
   localparam logic [SHIFT_BITS-1:0] SHIFT_MIN   = SHIFT_BITS'(1);
   localparam logic [SHIFT_BITS-1:0] SHIFT_MAX   = SHIFT_BITS'(16);

   localparam logic [INDEX_BITS-1:0] Y_BASE = INDEX_BITS'(X_DEPTH);

   typedef enum logic {
      OP_STEP = 1'b0,
      OP_LOAD = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [INDEX_BITS-1:0]   idx;
      logic [SEED_BITS-1:0]    value;
   } item_type;

endpackage

/* src/lakg_csr.sv */
// ----------------------------------------------------------------------------
// lakg_csr: shift amount register
// Holds s, clamped into its legal range when written.
// ----------------------------------------------------------------------------
module lakg_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lakg_pkg::SHIFT_BITS-1:0] csr_data,
   output logic [lakg_pkg::SHIFT_BITS-1:0] shift
);
   import lakg_pkg::*;

   logic [SHIFT_BITS-1:0] shift_ff;
   logic [SHIFT_BITS-1:0] shift_in;

   assign csr_ready = 1'b1;

   // clamp zero up to one and anything above sixteen down to sixteen
   always_comb begin
      shift_in = shift_ff;
      if (csr_valid) begin
         if (csr_data < SHIFT_MIN) begin
            shift_in = SHIFT_MIN;
         end else if (csr_data > SHIFT_MAX) begin
            shift_in = SHIFT_MAX;
         end else begin
            shift_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_RESET;
      end else begin
         shift_ff <= shift_in;
      end
   end

   assign shift = shift_ff;

endmodule

/* src/lakg_in_stage.sv */
// ----------------------------------------------------------------------------
// lakg_in_stage: input register
// Captures one request beat and releases it when the result side has room or the beat is a load.
// ----------------------------------------------------------------------------
module lakg_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  lakg_pkg::item_type   req_item,
   input  logic                 out_free,
   output logic                 fire,
   output lakg_pkg::item_type   item
);
   import lakg_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // a load never produces a beat, so it may leave even with the output full
   assign fire       = valid_ff && ((item_ff.op == OP_LOAD) || out_free);
   assign req_tready = !valid_ff || fire;
   assign valid_in   = req_tvalid || (valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item = item_ff;

endmodule

/* src/lakg_lag.sv */
// ----------------------------------------------------------------------------
// lakg_lag: lag registers and mixing step
// Holds X and Y, loads seeds, and computes tx, ty and the keystream word.
// ----------------------------------------------------------------------------
module lakg_lag #(
   parameter int WORD_BITS = lakg_pkg::WORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  lakg_pkg::item_type              item,
   input  logic [lakg_pkg::SHIFT_BITS-1:0] shift,
   output logic [WORD_BITS-1:0]            key
);
   import lakg_pkg::*;

   localparam int WIDTH_BITS = SHIFT_BITS + 2;

   logic [WORD_BITS-1:0]  x_ff [X_DEPTH];
   logic [WORD_BITS-1:0]  x_in [X_DEPTH];
   logic [WORD_BITS-1:0]  y_ff [Y_DEPTH];
   logic [WORD_BITS-1:0]  y_in [Y_DEPTH];
   logic [WIDTH_BITS-1:0] width_w;
   logic [WORD_BITS-1:0]  mask_w;
   logic [WORD_BITS-1:0]  tx_w;
   logic [WORD_BITS-1:0]  ty_w;
   logic [WORD_BITS-1:0]  seed_w;
   logic [Y_IDX_BITS-1:0] y_idx_w;

   assign width_w = {shift, 2'b00};

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         mask_w[i] = (WIDTH_BITS'(i) < width_w);
      end
   end

   assign tx_w = ((x_ff[4] ^ (y_ff[0] << shift)) + (x_ff[1] ^ (y_ff[2] >> shift))) & mask_w;
   assign ty_w = ((y_ff[2] ^ (x_ff[1] << shift)) + (y_ff[0] ^ (x_ff[4] >> shift))) & mask_w;
   assign key  = tx_w ^ ty_w;

   assign seed_w  = item.value[WORD_BITS-1:0] & mask_w;
   assign y_idx_w = Y_IDX_BITS'(item.idx - Y_BASE);

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (fire) begin
         if (item.op == OP_LOAD) begin
            if (item.idx < Y_BASE) begin
               x_in[item.idx] = seed_w;
            end else begin
               y_in[y_idx_w] = seed_w;
            end
         end else begin
            // advance both lines by one word
            for (int j = X_DEPTH - 1; j > 0; j--) begin
               x_in[j] = x_ff[j-1];
            end
            x_in[0] = tx_w;
            for (int j = Y_DEPTH - 1; j > 0; j--) begin
               y_in[j] = y_ff[j-1];
            end
            y_in[0] = ty_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < X_DEPTH; j++) begin
            x_ff[j] <= '0;
         end
         for (int j = 0; j < Y_DEPTH; j++) begin
            y_ff[j] <= '0;
         end
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

endmodule

/* src/lagged_add_xor_keystream_generator_core.sv */
// ----------------------------------------------------------------------------
// lagged_add_xor_keystream_generator_core: top level
// Two-lag add-xor keystream generator with a streaming request and response.
// ----------------------------------------------------------------------------
// Each request beat is either a seed load (tuser = 1), which writes one word
// of X0-X4 (index 0-4) or Y0-Y2 (index 5-7) masked to 4*s bits and produces
// no response, or a step (tuser = 0), which produces exactly one response beat
// carrying tx ^ ty and then shifts tx into X and ty into Y. A beat is captured
// in an input register, mixed combinationally by two adders and barrel
// shifters, and the result is held in an output register, so the block
// sustains one beat per cycle. The pipeline only stalls when the response
// register is full and not taken. The word width is the smaller of 4*s and
// WORD_BITS. The shift s is written through the csr port (clamped to 1..16,
// reset 2) while the block is idle; the user must ensure this, not the block.
// ----------------------------------------------------------------------------
module lagged_add_xor_keystream_generator_core #(
   parameter int WORD_BITS = lakg_pkg::WORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: tdata = seed_index[2:0], seed_value[66:3], zero pad to 72 bits
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [71:0]                      req_tdata,
   input  logic                             req_tuser,  // operation
   // response: tdata = keystream_word[63:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lakg_pkg::KEY_BITS-1:0]    rsp_tdata,
   // shift amount register write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lakg_pkg::SHIFT_BITS-1:0]  csr_data
);
   import lakg_pkg::*;

   item_type              req_item_w;
   item_type              item_w;
   logic                  fire_w;
   logic                  out_free_w;
   logic [SHIFT_BITS-1:0] shift_w;
   logic [WORD_BITS-1:0]  key_w;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [KEY_BITS-1:0]   rsp_data_ff;

   // unpack the request beat
   assign req_item_w.op    = op_type'(req_tuser);
   assign req_item_w.idx   = req_tdata[INDEX_BITS-1:0];
   assign req_item_w.value = req_tdata[INDEX_BITS +: SEED_BITS];

   lakg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .shift     (shift_w)
   );

   lakg_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item_w),
      .out_free   (out_free_w),
      .fire       (fire_w),
      .item       (item_w)
   );

   lakg_lag #(
      .WORD_BITS (WORD_BITS)
   ) u_lag (
      .clock (clock),
      .reset (reset),
      .fire  (fire_w),
      .item  (item_w),
      .shift (shift_w),
      .key   (key_w)
   );

   // output register has room when empty or being drained this cycle
   assign out_free_w = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (fire_w && (item_w.op == OP_STEP)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the word until the beat is taken; load only on a step
   always_ff @(posedge clock) begin
      if (fire_w && (item_w.op == OP_STEP)) begin
         rsp_data_ff <= KEY_BITS'(key_w);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* dv/tb_lagged_add_xor_keystream_generator_core.sv */
// ----------------------------------------------------------------------------
// tb_lagged_add_xor_keystream_generator_core: self-checking testbench
// Drives seed loads and keystream steps through the request stream. An
// in-bench generator model predicts each word not given by a directed row,
// and the response stream is checked in order. The shift setting is swept
// across its extremes, out-of-range and mid-range values while the block is
// idle. Both stream sides idle at random, and the receiver holds off once for
// a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_lagged_add_xor_keystream_generator_core;
   import lakg_pkg::*;

   localparam int IDLE_LIMIT   = 2000;  // cycles with no beat before giving up
   localparam int LONG_HOLD    = 300;   // receiver hold-off in the pressure phase
   localparam int DRAIN_CYCLES = 4;     // lets trailing loads, which give no beat, reach the lag registers
   localparam int PHASE_ITEMS  = 80;
   localparam int N_PHASES     = 7;
   localparam int N_DIRECTED   = 22;
   localparam int PRINT_CAP    = 50;

   typedef struct packed {
      op_type                  op;
      logic [INDEX_BITS-1:0]   idx;
      logic [SEED_BITS-1:0]    value;
      logic                    typed;   // compare with word instead of the model
      logic [KEY_BITS-1:0]     word;
   } directed_row_type;

   // Runs at the reset shift of 2, so every word is 8 bits wide.
   directed_row_type directed_rows [N_DIRECTED] = '{
      '{OP_STEP, 3'd0, 64'h0,                 1'b1, 64'h0},   // zero state after reset
      '{OP_STEP, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0}, // seed fields ignored on a step
      '{OP_LOAD, 3'd4, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0}, // masked down to 8'hFF
      '{OP_STEP, 3'd0, 64'h0,                 1'b1, 64'hC0},  // 8'hFF ^ 8'h3F
      '{OP_LOAD, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      '{OP_LOAD, 3'd1, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
      '{OP_LOAD, 3'd2, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
      '{OP_LOAD, 3'd3, 64'h0123_4567_89AB_CDEF, 1'b0, 64'h0},
      '{OP_LOAD, 3'd4, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
      '{OP_LOAD, 3'd5, 64'h0000_0000_0000_0001, 1'b0, 64'h0},
      '{OP_LOAD, 3'd6, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      '{OP_LOAD, 3'd7, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0, 64'h0},
      '{OP_STEP, 3'd0, 64'h0,                 1'b0, 64'h0},
      '{OP_STEP, 3'd5, 64'h1234,              1'b0, 64'h0},
      '{OP_STEP, 3'd0, 64'h0,                 1'b0, 64'h0},
      '{OP_STEP, 3'd0, 64'h0,                 1'b0, 64'h0},
      '{OP_STEP, 3'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      '{OP_STEP, 3'd0, 64'h0,                 1'b0, 64'h0},
      '{OP_LOAD, 3'd5, 64'h0,                 1'b0, 64'h0},
      '{OP_STEP, 3'd0, 64'h0,                 1'b0, 64'h0},
      '{OP_LOAD, 3'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      '{OP_STEP, 3'd0, 64'h0,                 1'b0, 64'h0}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [71:0]             req_tdata = '0;   // seed_index[2:0], seed_value[66:3], pad
   logic                    req_tuser = 1'b0; // operation
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [KEY_BITS-1:0]     rsp_tdata;        // keystream_word[63:0]
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [SHIFT_BITS-1:0]   csr_data = SHIFT_RESET;

   // generator model state
   logic [SHIFT_BITS-1:0]   shift_setting = SHIFT_RESET;
   logic [63:0]             x_words [X_DEPTH];
   logic [63:0]             y_words [Y_DEPTH];
   logic [KEY_BITS-1:0]     keystream_expect_q [$];

   int                      mismatch_count = 0;
   int                      idle_cycles = 0;
   int                      tx_calm_left = 0;
   int                      rx_calm_left = 0;
   int                      rx_hold_left = 0;
   bit                      burst_mode = 1'b0;
   bit                      long_hold_req = 1'b0;
   logic [KEY_BITS-1:0]     want_word;

   lagged_add_xor_keystream_generator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Apply one accepted beat to the model; return 1 when it yields a word.
   function automatic bit advance_generator(input op_type op,
                                            input logic [INDEX_BITS-1:0] idx,
                                            input logic [SEED_BITS-1:0] value,
                                            output logic [KEY_BITS-1:0] word);
      int unsigned s;
      logic [63:0] mask;
      logic [63:0] tx;
      logic [63:0] ty;
      if (shift_setting < SHIFT_MIN) s = SHIFT_MIN;
      else if (shift_setting > SHIFT_MAX) s = SHIFT_MAX;
      else s = shift_setting;
      mask = (4 * s >= 64) ? '1 : ((64'd1 << (4 * s)) - 64'd1);
      word = '0;
      if (op == OP_LOAD) begin
         if (idx < Y_BASE) x_words[idx] = value & mask;
         else y_words[idx - Y_BASE] = value & mask;
         return 1'b0;
      end
      tx = ((x_words[4] ^ (y_words[0] << s)) + (x_words[1] ^ (y_words[2] >> s))) & mask;
      ty = ((y_words[2] ^ (x_words[1] << s)) + (y_words[0] ^ (x_words[4] >> s))) & mask;
      word = tx ^ ty;
      for (int j = X_DEPTH - 1; j > 0; j--) x_words[j] = x_words[j - 1];
      x_words[0] = tx;
      for (int j = Y_DEPTH - 1; j > 0; j--) y_words[j] = y_words[j - 1];
      y_words[0] = ty;
      return 1'b1;
   endfunction

   function automatic logic [63:0] draw_seed_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offer one request beat after a random gap; predict it once accepted.
   task automatic send_item(input op_type op, input logic [INDEX_BITS-1:0] idx,
                            input logic [SEED_BITS-1:0] value, input bit typed,
                            input logic [KEY_BITS-1:0] typed_word);
      int gap;
      logic [KEY_BITS-1:0] word;
      gap = (burst_mode || tx_calm_left > 0) ? 0 : $urandom_range(0, 14);
      if (tx_calm_left > 0) tx_calm_left--;
      else if ($urandom_range(0, 9) == 0) tx_calm_left = $urandom_range(10, 30);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, value, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (advance_generator(op, idx, value, word))
         keystream_expect_q.push_back(typed ? typed_word : word);
   endtask

   // Drain all outstanding work, then write the shift register.
   task automatic write_shift(input logic [SHIFT_BITS-1:0] value);
      req_tvalid <= 1'b0;
      while (keystream_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      shift_setting = value;
   endtask

   // Response side: check each beat, then draw the hold-off before the next.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready   <= 1'b0;
         rx_hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (keystream_expect_q.size() == 0) begin
               report_mismatch("unexpected keystream beat", rsp_tdata, '0);
            end else begin
               want_word = keystream_expect_q.pop_front();
               if (rsp_tdata !== want_word)
                  report_mismatch("keystream_word", rsp_tdata, want_word);
            end
            rx_hold_left = (rx_calm_left > 0) ? 0 : $urandom_range(0, 14);
            if (rx_calm_left > 0) rx_calm_left--;
            else if ($urandom_range(0, 9) == 0) rx_calm_left = $urandom_range(10, 30);
         end
         if (long_hold_req) begin
            rx_hold_left  = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (rx_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rx_hold_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [SHIFT_BITS-1:0] shift_plan [N_PHASES];
      op_type op;
      foreach (x_words[i]) x_words[i] = '0;
      foreach (y_words[i]) y_words[i] = '0;
      // extremes, out-of-range values on both sides, a mid-range and an out-of-range pick, then the reset value
      shift_plan[0] = SHIFT_MIN;
      shift_plan[1] = SHIFT_MAX;
      shift_plan[2] = '0;
      shift_plan[3] = '1;
      shift_plan[4] = SHIFT_BITS'($urandom_range(3, 15));
      shift_plan[5] = SHIFT_BITS'($urandom_range(17, 30));
      shift_plan[6] = SHIFT_RESET;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_item(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].value,
                   directed_rows[r].typed, directed_rows[r].word);

      for (int p = 0; p < N_PHASES; p++) begin
         write_shift(shift_plan[p]);
         // stall the receiver while the sender streams without gaps
         burst_mode = (p == 1);
         if (p == 1) long_hold_req = 1'b1;
         for (int i = 0; i < X_DEPTH + Y_DEPTH; i++)
            send_item(OP_LOAD, INDEX_BITS'(i), draw_seed_word(), 1'b0, '0);
         for (int n = X_DEPTH + Y_DEPTH; n < PHASE_ITEMS; n++) begin
            op = ($urandom_range(0, 3) == 0) ? OP_LOAD : OP_STEP;
            send_item(op, INDEX_BITS'($urandom_range(0, 7)), draw_seed_word(), 1'b0, '0);
            if (n == 48) burst_mode = 1'b0;
         end
         burst_mode = 1'b0;
      end

      req_tvalid <= 1'b0;
      while (keystream_expect_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && keystream_expect_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/lakg_pkg.sv
src/lakg_csr.sv
src/lakg_in_stage.sv
src/lakg_lag.sv
src/lagged_add_xor_keystream_generator_core.sv
dv/tb_lagged_add_xor_keystream_generator_core.sv
